// ----- hdl/incremental_insertion_sorter_macros.svh -----
// assertion macros for the insertion sorter
// each check is sampled on the rising clock edge and is off while reset is low
`ifndef INCREMENTAL_INSERTION_SORTER_MACROS_SVH
`define INCREMENTAL_INSERTION_SORTER_MACROS_SVH

`ifndef SYNTHESIS

`define IIS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("insertion sorter check failed");

`define IIS_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("insertion sorter forbidden condition");

`else

`define IIS_ASSERT(lbl, prop)

`define IIS_ASSERT_NEVER(lbl, cond)

`endif

`endif

// ----- hdl/iis_pkg.sv -----
`default_nettype none

package iis_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_OVERFLOW
  } state_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ROTATE
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e mode;
    logic       clear;
  } cell_ctrl_t;

  localparam int unsigned ELEM_W = 32;
  localparam int unsigned POS_W  = 4;

endpackage

`default_nettype wire

// ----- hdl/incremental_insertion_sorter.sv -----
// output: the run of results starts the cycle after a request is accepted; an overflow
// result also comes in the cycle after; the first value of a set gives no result
// busy: after an insertion that emits, busy stays high while the cell ring rotates
// one full turn to read out and restore the list, and while an overflow result is shown
// reset clears the fill count and all cell valid bits at once; stored values stay undefined
// the receiver cannot stall: each result is on the ports for exactly one cycle
`default_nettype none

`include "incremental_insertion_sorter_macros.svh"

module incremental_insertion_sorter import iis_pkg::*; #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic signed [ELEM_W-1:0] new_value_i,
  input  wire logic                     start_set_i,
  output logic                          result_valid_o,
  output logic signed [ELEM_W-1:0]      element_o,
  output logic [POS_W-1:0]              position_o,
  output logic                          last_of_run_o,
  output logic                          overflow_o
);

  localparam int unsigned CNT_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [FILL_W-1:0]  fill_new;
  logic [FILL_W-1:0]  cnt_ext;
  logic               accept;
  logic               ovf_req;
  logic               ins_req;
  cell_ctrl_t         cell_ctrl;

  logic signed [VALUE_WIDTH-1:0] ins_value;
  logic signed [VALUE_WIDTH-1:0] cell_val   [DEPTH];
  logic [DEPTH-1:0]              cell_valid;
  logic [DEPTH-1:0]              cell_occ;
  logic [DEPTH-1:0]              cell_shift;

  assign accept    = start & ~busy;
  assign ovf_req   = accept & ~start_set_i & (fill_q == FILL_W'(DEPTH));
  assign ins_req   = accept & ~ovf_req;
  assign fill_new  = (start_set_i ? '0 : fill_q) + FILL_W'(1);
  assign ins_value = VALUE_WIDTH'(new_value_i);
  assign cnt_ext   = FILL_W'(cnt_q);

  // cell chain: insertion pushes toward higher positions, readout rotates toward cell 0
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam int unsigned NEXT = (g + 1) % DEPTH;
    if (g == 0) begin : g_head
      iis_cell #(
        .VALUE_WIDTH(VALUE_WIDTH)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (cell_ctrl),
        .ins_value_i  (ins_value),
        .left_val_i   (ins_value),
        .left_occ_i   (1'b1),
        .left_shift_i (1'b0),
        .right_val_i  (cell_val[NEXT]),
        .right_valid_i(cell_valid[NEXT]),
        .val_o        (cell_val[g]),
        .valid_o      (cell_valid[g]),
        .occ_o        (cell_occ[g]),
        .shift_o      (cell_shift[g])
      );
    end else begin : g_body
      iis_cell #(
        .VALUE_WIDTH(VALUE_WIDTH)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (cell_ctrl),
        .ins_value_i  (ins_value),
        .left_val_i   (cell_val[g-1]),
        .left_occ_i   (cell_occ[g-1]),
        .left_shift_i (cell_shift[g-1]),
        .right_val_i  (cell_val[NEXT]),
        .right_valid_i(cell_valid[NEXT]),
        .val_o        (cell_val[g]),
        .valid_o      (cell_valid[g]),
        .occ_o        (cell_occ[g]),
        .shift_o      (cell_shift[g])
      );
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = '0;
    fill_d  = fill_q;
    if (ins_req) begin
      fill_d = fill_new;
    end
    case (state_q)
      ST_IDLE: begin
        if (ovf_req) begin
          state_d = ST_OVERFLOW;
        end else if (ins_req && (fill_new >= FILL_W'(2))) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
          cnt_d   = '0;
        end
      end
      ST_OVERFLOW: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs and cell control
  always_comb begin
    busy           = 1'b1;
    result_valid_o = 1'b0;
    element_o      = '0;
    position_o     = '0;
    last_of_run_o  = 1'b0;
    overflow_o     = 1'b0;
    cell_ctrl      = '{mode: CELL_HOLD, clear: start_set_i};
    case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (ins_req) begin
          cell_ctrl.mode = CELL_INSERT;
        end
      end
      ST_EMIT: begin
        cell_ctrl.mode = CELL_ROTATE;
        // cell 0 holds entry cnt_q; the rest of the turn only restores the list
        result_valid_o = cnt_ext < fill_q;
        element_o      = ELEM_W'(cell_val[0]);
        position_o     = POS_W'(cnt_q);
        last_of_run_o  = (cnt_ext + FILL_W'(1)) == fill_q;
      end
      ST_OVERFLOW: begin
        result_valid_o = 1'b1;
        last_of_run_o  = 1'b1;
        overflow_o     = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      fill_q  <= fill_d;
    end
  end

  `IIS_ASSERT(a_full_gives_overflow, (accept && !start_set_i && (fill_q == FILL_W'(DEPTH))) |=> (result_valid_o && overflow_o && last_of_run_o))
  `IIS_ASSERT(a_idle_valid_matches_fill, (state_q == ST_IDLE) |-> ($countones(cell_valid) == int'(fill_q)))
  `IIS_ASSERT_NEVER(a_fill_in_range, fill_q > FILL_W'(DEPTH))
  `IIS_ASSERT(a_run_entry_valid, (result_valid_o && !overflow_o) |-> cell_valid[0])

endmodule

`default_nettype wire

// ----- hdl/iis_cell.sv -----
`default_nettype none

module iis_cell import iis_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire cell_ctrl_t                    ctrl_i,
  input  wire logic signed [VALUE_WIDTH-1:0] ins_value_i,
  input  wire logic signed [VALUE_WIDTH-1:0] left_val_i,
  input  wire logic                          left_occ_i,
  input  wire logic                          left_shift_i,
  input  wire logic signed [VALUE_WIDTH-1:0] right_val_i,
  input  wire logic                          right_valid_i,
  output logic signed [VALUE_WIDTH-1:0]      val_o,
  output logic                               valid_o,
  output logic                               occ_o,
  output logic                               shift_o
);

  logic signed [VALUE_WIDTH-1:0] val_q, val_d;
  logic                          valid_q, valid_d;
  logic                          occ;
  logic                          shift;

  // a new set sees every cell as empty
  assign occ   = valid_q & ~ctrl_i.clear;
  assign shift = occ & (ins_value_i < val_q);

  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    case (ctrl_i.mode)
      CELL_INSERT: begin
        if (left_shift_i) begin
          val_d   = left_val_i;
          valid_d = 1'b1;
        end else if (shift || (!occ && left_occ_i)) begin
          val_d   = ins_value_i;
          valid_d = 1'b1;
        end else begin
          valid_d = occ;
        end
      end
      CELL_ROTATE: begin
        val_d   = right_val_i;
        valid_d = right_valid_i;
      end
      default: begin
        val_d   = val_q;
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o   = val_q;
  assign valid_o = valid_q;
  assign occ_o   = occ;
  assign shift_o = shift;

endmodule

`default_nettype wire
